/* design/skl_pkg.sv */
// ----------------------------------------------------------------------------
// skl_pkg
// shared types and constants for the sorted key lookup block
// ----------------------------------------------------------------------------
package skl_pkg;

    // field widths
    localparam int PAGE_W  = 32;
    localparam int ITEM_W  = 16;
    localparam int KEY_W   = PAGE_W + ITEM_W;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;

    // input action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // write one table entry
        logic start;    // begin a search with the input key
        logic retry;    // restart the search with item id zero
        logic rd_mid;   // read the entry at the probe point
        logic rd_first; // read the entry at the lower bound
        logic step;     // narrow the range from the read key
        logic set_hit;  // record an exact match
        logic clr_hit;  // record a miss
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;     // search range is empty
        logic first_ge_limit; // lower bound is past the searched entries
        logic key_eq;         // read key equals the target
        logic can_retry;      // item-zero retry is allowed and not yet done
    } t_dp_sts;

endpackage

/* design/skl_ram.sv */
// ----------------------------------------------------------------------------
// skl_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module skl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/skl_ctrl.sv */
// ----------------------------------------------------------------------------
// skl_ctrl
// sequencer for loads, lower-bound probes, final check and fallback retry
// ----------------------------------------------------------------------------
module skl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_action,
    output logic               o_ready,
    input  logic               i_out_free,
    output logic               o_publish,
    input  skl_pkg::t_dp_sts   i_sts,
    output skl_pkg::t_dp_cmd   o_cmd
);

    import skl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PROBE = 5'b00010,
        S_STEP  = 5'b00100,
        S_FCHK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_ready   = 1'b0;
        o_publish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action == ACT_LOOKUP) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PROBE;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                if (!i_sts.count_zero) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_STEP;
                end else if (!i_sts.first_ge_limit) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_FCHK;
                end else if (i_sts.can_retry) begin
                    o_cmd.retry = 1'b1;
                end else begin
                    o_cmd.clr_hit = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_PROBE;
            end
            S_FCHK: begin
                if (i_sts.key_eq) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.can_retry) begin
                    o_cmd.retry = 1'b1;
                    n_state     = S_PROBE;
                end else begin
                    o_cmd.clr_hit = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_publish = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/skl_dp.sv */
// ----------------------------------------------------------------------------
// skl_dp
// key table, search range registers and key compare
// ----------------------------------------------------------------------------
module skl_dp #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  skl_pkg::t_dp_cmd            i_cmd,
    output skl_pkg::t_dp_sts            o_sts,
    input  logic [skl_pkg::CNT_W-1:0]   i_entry_count,
    input  logic [skl_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [skl_pkg::PAGE_W-1:0]  i_page_id,
    input  logic [skl_pkg::ITEM_W-1:0]  i_item_id,
    input  logic                        i_allow_fallback,
    output logic                        o_found,
    output logic [skl_pkg::IDX_W-1:0]   o_match_index,
    output logic                        o_used_fallback
);

    import skl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [PAGE_W-1:0] r_page;
    logic [ITEM_W-1:0] r_item;
    logic              r_fb;
    logic              r_phase;
    logic              r_hit;
    logic [CW-1:0]     r_first;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_limit;

    logic [CW-1:0]     w_half;
    logic [CW-1:0]     w_mid;
    logic [CW-1:0]     w_start_limit;
    logic [AW-1:0]     w_addr;
    logic [31:0]       w_load_ext;
    logic              w_load_ok;
    logic [KEY_W-1:0]  w_rdata;
    logic [KEY_W-1:0]  w_target;
    logic [31:0]       w_first_ext;

    // probe point and search limit
    assign w_half   = r_count >> 1;
    assign w_mid    = r_first + w_half;
    assign w_target = {r_page, r_item};
    assign w_start_limit = (32'(i_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                  : CW'(i_entry_count);

    // load slot range check
    assign w_load_ext = 32'(i_entry_index);
    assign w_load_ok  = w_load_ext < 32'(TABLE_DEPTH);

    // memory address select
    always_comb begin
        if (i_cmd.load) begin
            w_addr = w_load_ext[AW-1:0];
        end else if (i_cmd.rd_first) begin
            w_addr = r_first[AW-1:0];
        end else begin
            w_addr = w_mid[AW-1:0];
        end
    end

    skl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_load_ok),
        .i_re    (i_cmd.rd_mid || i_cmd.rd_first),
        .i_addr  (w_addr),
        .i_wdata ({i_page_id, i_item_id}),
        .o_rdata (w_rdata)
    );

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page  <= i_page_id;
            r_item  <= i_item_id;
            r_fb    <= i_allow_fallback;
            r_phase <= 1'b0;
            r_first <= '0;
            r_count <= w_start_limit;
            r_limit <= w_start_limit;
        end else if (i_cmd.retry) begin
            r_item  <= '0;
            r_phase <= 1'b1;
            r_first <= '0;
            r_count <= r_limit;
        end else if (i_cmd.step) begin
            // r_first was held since the read, so w_mid is the probed slot
            if (w_rdata < w_target) begin
                r_first <= w_mid + CW'(1);
                r_count <= r_count - w_half - CW'(1);
            end else begin
                r_count <= w_half;
            end
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end else if (i_cmd.clr_hit) begin
            r_hit <= 1'b0;
        end
    end

    // status
    assign o_sts.count_zero     = (r_count == '0);
    assign o_sts.first_ge_limit = (r_first >= r_limit);
    assign o_sts.key_eq         = (w_rdata == w_target);
    assign o_sts.can_retry      = !r_phase && r_fb && (r_item != '0);

    // result
    assign w_first_ext     = 32'(r_first);
    assign o_found         = r_hit;
    assign o_match_index   = r_hit ? w_first_ext[IDX_W-1:0] : '0;
    assign o_used_fallback = r_hit && r_phase;

endmodule

/* design/sorted_key_lookup_with_fallback_core.sv */
// ----------------------------------------------------------------------------
// sorted_key_lookup_with_fallback_core
// sorted two-part key table with lower-bound search and item-zero fallback
// ----------------------------------------------------------------------------
// Usage:
//   config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) sets entry_count;
//   write it only while the block is idle. It is always ready.
//   input channel (i_valid/o_ready) takes load and lookup items. A load
//   writes one slot and gives no result. A lookup gives one result on
//   the output channel (o_valid/i_ready).
//   Search: the binary search takes up to 13 probes for 4096 entries;
//   every probe reads the single-port table ram, then compares the read
//   key. The final exact-match check costs one read. A fallback retry
//   runs a second search. The answer then moves into the output register.
//   One lookup is worked on at a time; o_ready is high only when idle.
//   A result held in the output register does not block loads or a new
//   lookup; a finished lookup waits while the receiver stalls.
//   Reset clears entry_count and the handshake state; the key table is
//   not cleared and must be loaded before it is searched.
// ----------------------------------------------------------------------------
module sorted_key_lookup_with_fallback_core #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [skl_pkg::CNT_W-1:0]   i_cfg_data,
    // input items
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [skl_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [skl_pkg::PAGE_W-1:0]  i_page_id,
    input  logic [skl_pkg::ITEM_W-1:0]  i_item_id,
    input  logic                        i_allow_fallback,
    // results
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [skl_pkg::IDX_W-1:0]   o_match_index,
    output logic                        o_used_fallback
);

    import skl_pkg::*;

    logic [CNT_W-1:0] r_entry_count;
    logic             r_out_valid;
    logic             r_found;
    logic [IDX_W-1:0] r_match_index;
    logic             r_used_fallback;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_out_free;
    logic             w_publish;
    logic             w_res_found;
    logic [IDX_W-1:0] w_res_index;
    logic             w_res_fb;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    skl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .o_ready    (o_ready),
        .i_out_free (w_out_free),
        .o_publish  (w_publish),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    skl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_entry_count    (r_entry_count),
        .i_entry_index    (i_entry_index),
        .i_page_id        (i_page_id),
        .i_item_id        (i_item_id),
        .i_allow_fallback (i_allow_fallback),
        .o_found          (w_res_found),
        .o_match_index    (w_res_index),
        .o_used_fallback  (w_res_fb)
    );

    // output register, free when empty or being taken
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_publish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_publish) begin
            r_found         <= w_res_found;
            r_match_index   <= w_res_index;
            r_used_fallback <= w_res_fb;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_match_index   = r_match_index;
    assign o_used_fallback = r_used_fallback;

`ifndef SYNTHESIS
    // a result is only moved into a free output register
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_publish |-> w_out_free)
        else $error("result published over an unread result");

    // a lookup transfer leaves the input side busy in the cycle after it
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_action == ACT_LOOKUP) |=> !o_ready)
        else $error("input ready right after lookup transfer");

    // a miss carries a zero index and no fallback flag
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_index == '0 && !o_used_fallback))
        else $error("miss result with nonzero fields");

    // the controller never commands a table write and a read together
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(w_cmd.rd_mid || w_cmd.rd_first))
        else $error("table write and read in the same cycle");
`endif

endmodule
